// File: rtl/q4q8_pkg.sv
// ----------------------------------------------------------------------------
// q4q8_pkg
// Shared types, constants and float helpers for the 4-bit x 8-bit block dot.
// ----------------------------------------------------------------------------
`default_nettype none

package q4q8_pkg;

    localparam int LANES      = 4;
    localparam int LANE_ELEMS = 8;
    localparam int DATA_W     = 416;
    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LANE,
        S_SCALE_W,
        S_TERM,
        S_TERM_W,
        S_ADD,
        S_ADD_W,
        S_EMIT
    } t_state;

    // value = mant * 2^(expo - 150)
    typedef struct packed {
        logic        sign;
        logic [8:0]  expo;
        logic [23:0] mant;
        logic        inf;
        logic        nan;
    } t_fop;

    // value = x * 2^(er - 174) before normalization to bit 47
    typedef struct packed {
        logic               sign;
        logic signed [12:0] er;
        logic [47:0]        x;
        logic               inf;
        logic               nan;
    } t_fmid;

    function automatic t_fop unpack_half(logic [15:0] h);
        t_fop r;
        r.sign = h[15];
        r.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
        r.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        if (h[14:10] == 5'd0) begin
            r.expo = 9'd126;
            r.mant = {14'd0, h[9:0]};
        end else begin
            r.expo = 9'({4'd0, h[14:10]} + 9'd125);
            r.mant = {13'd0, 1'b1, h[9:0]};
        end
        return r;
    endfunction

    function automatic t_fop unpack_float(logic [31:0] f);
        t_fop r;
        r.sign = f[31];
        r.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
        r.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
        if (f[30:23] == 8'd0) begin
            r.expo = 9'd1;
            r.mant = {1'b0, f[22:0]};
        end else begin
            r.expo = {1'b0, f[30:23]};
            r.mant = {1'b1, f[22:0]};
        end
        return r;
    endfunction

    function automatic t_fop unpack_int(logic signed [16:0] v);
        t_fop        r;
        logic [16:0] mag;
        mag    = v[16] ? 17'(-v) : 17'(v);
        r.sign = v[16];
        r.expo = 9'd150;
        r.mant = 24'(mag);
        r.inf  = 1'b0;
        r.nan  = 1'b0;
        return r;
    endfunction

    function automatic logic [5:0] lzc48(logic [47:0] x);
        logic [5:0] lz;
        logic       found;
        lz    = 6'd48;
        found = 1'b0;
        for (int i = 0; i < 48; i++) begin
            if (!found && x[47 - i]) begin
                lz    = 6'(i);
                found = 1'b1;
            end
        end
        return lz;
    endfunction

    function automatic t_fmid normalize(t_fmid m);
        t_fmid      r;
        logic [5:0] lz;
        lz   = lzc48(m.x);
        r    = m;
        r.x  = m.x << lz;
        r.er = m.er - $signed({7'd0, lz});
        return r;
    endfunction

    function automatic logic [31:0] round_pack(logic sign, logic signed [12:0] er,
                                               logic [47:0] x);
        logic [12:0] sh_full;
        logic [5:0]  sh;
        logic [47:0] xs;
        logic        st;
        logic [12:0] ee;
        logic [23:0] mant;
        logic        g;
        logic        s;
        logic        rnd;
        logic [24:0] m25;
        logic [35:0] full;
        logic [31:0] r;
        if (er < 13'sd1) begin
            sh_full = 13'(13'sd1 - er);
            sh      = (sh_full > 13'd63) ? 6'd63 : sh_full[5:0];
            xs      = x >> sh;
            st      = ((xs << sh) != x);
            ee      = 13'd1;
        end else begin
            xs = x;
            st = 1'b0;
            ee = 13'(er);
        end
        mant = xs[47:24];
        g    = xs[23];
        s    = (|xs[22:0]) | st;
        rnd  = g & (s | mant[0]);
        m25  = {1'b0, mant} + 25'(rnd);
        full = {13'(ee - 13'd1), 23'd0} + 36'(m25);
        if (x == 48'd0) begin
            r = {sign, 31'd0};
        end else if (full[35:23] >= 13'd255) begin
            r = {sign, 8'hFF, 23'd0};
        end else begin
            r = {sign, full[30:0]};
        end
        return r;
    endfunction

    function automatic logic [31:0] finish(t_fmid m);
        logic [31:0] r;
        if (m.nan) begin
            r = QNAN;
        end else if (m.inf) begin
            r = {m.sign, 8'hFF, 23'd0};
        end else begin
            r = round_pack(m.sign, m.er, m.x);
        end
        return r;
    endfunction

    function automatic logic [31:0] canon_nan(logic [31:0] f);
        logic [31:0] r;
        r = ((f[30:23] == 8'hFF) && (f[22:0] != 23'd0)) ? QNAN : f;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/q4q8_lane.sv
// ----------------------------------------------------------------------------
// q4q8_lane
// One lane: eight 4-bit x 8-bit products from four code bytes, summed.
// ----------------------------------------------------------------------------
`default_nettype none

module q4q8_lane (
    input  wire logic               i_clk,
    input  wire logic [31:0]        i_codes,
    input  wire logic [63:0]        i_acts,
    output logic signed [14:0]      o_sum
);

    logic signed [14:0] n_sum;
    logic signed [14:0] r_sum;

    always_comb begin
        logic signed [4:0]  w_lo;
        logic signed [4:0]  w_hi;
        logic signed [7:0]  a_lo;
        logic signed [7:0]  a_hi;
        logic signed [12:0] p_lo;
        logic signed [12:0] p_hi;
        n_sum = '0;
        for (int k = 0; k < q4q8_pkg::LANE_ELEMS / 2; k++) begin
            w_lo  = $signed({1'b0, i_codes[8*k +: 4]}) - 5'sd8;
            w_hi  = $signed({1'b0, i_codes[8*k+4 +: 4]}) - 5'sd8;
            a_lo  = $signed(i_acts[16*k +: 8]);
            a_hi  = $signed(i_acts[16*k+8 +: 8]);
            p_lo  = 13'(w_lo) * 13'(a_lo);
            p_hi  = 13'(w_hi) * 13'(a_hi);
            n_sum = n_sum + 15'(p_lo) + 15'(p_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// File: rtl/q4q8_fmul.sv
// ----------------------------------------------------------------------------
// q4q8_fmul
// Three-stage single-precision multiplier, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module q4q8_fmul (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire q4q8_pkg::t_fop i_a,
    input  wire q4q8_pkg::t_fop i_b,
    output logic                o_valid,
    output logic [31:0]         o_res
);

    q4q8_pkg::t_fmid n_s1;
    q4q8_pkg::t_fmid r_s1;
    q4q8_pkg::t_fmid r_s2;
    logic [31:0]     r_res;
    logic [2:0]      r_v;

    always_comb begin
        logic a_zero;
        logic b_zero;
        a_zero  = (i_a.mant == 24'd0) && !i_a.inf && !i_a.nan;
        b_zero  = (i_b.mant == 24'd0) && !i_b.inf && !i_b.nan;
        n_s1.sign = i_a.sign ^ i_b.sign;
        n_s1.er   = $signed({4'd0, i_a.expo}) + $signed({4'd0, i_b.expo}) - 13'sd126;
        n_s1.x    = i_a.mant * i_b.mant;
        n_s1.inf  = i_a.inf | i_b.inf;
        n_s1.nan  = i_a.nan | i_b.nan | (i_a.inf & b_zero) | (i_b.inf & a_zero);
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= q4q8_pkg::normalize(r_s1);
        r_res <= q4q8_pkg::finish(r_s2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: rtl/q4q8_fadd.sv
// ----------------------------------------------------------------------------
// q4q8_fadd
// Three-stage single-precision adder, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module q4q8_fadd (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_valid,
    output logic [31:0]      o_res
);

    q4q8_pkg::t_fmid n_s1;
    q4q8_pkg::t_fmid r_s1;
    q4q8_pkg::t_fmid r_s2;
    logic [31:0]     r_res;
    logic [2:0]      r_v;

    always_comb begin
        q4q8_pkg::t_fop a;
        q4q8_pkg::t_fop b;
        q4q8_pkg::t_fop big;
        q4q8_pkg::t_fop sml;
        logic [8:0]  d;
        logic [4:0]  dsh;
        logic [26:0] ext;
        logic [26:0] shf;
        logic [26:0] al;
        logic [27:0] s;
        logic        sub;
        a   = q4q8_pkg::unpack_float(i_a);
        b   = q4q8_pkg::unpack_float(i_b);
        if ({a.expo, a.mant} >= {b.expo, b.mant}) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        sub = a.sign ^ b.sign;
        d   = big.expo - sml.expo;
        dsh = (d > 9'd31) ? 5'd31 : d[4:0];
        ext = {sml.mant, 3'b000};
        shf = ext >> dsh;
        al  = {shf[26:1], shf[0] | ((shf << dsh) != ext)};
        s   = sub ? ({1'b0, big.mant, 3'b000} - {1'b0, al})
                  : ({1'b0, big.mant, 3'b000} + {1'b0, al});
        n_s1.er  = $signed({4'd0, big.expo}) + 13'sd1;
        n_s1.x   = {s, 20'd0};
        n_s1.nan = a.nan | b.nan | (a.inf & b.inf & sub);
        n_s1.inf = a.inf | b.inf;
        if (a.inf) begin
            n_s1.sign = a.sign;
        end else if (b.inf) begin
            n_s1.sign = b.sign;
        end else if (s == 28'd0) begin
            n_s1.sign = a.sign & b.sign;
        end else begin
            n_s1.sign = big.sign;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= q4q8_pkg::normalize(r_s1);
        r_res <= q4q8_pkg::finish(r_s2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: rtl/quant4_int8_block_dot.sv
// ----------------------------------------------------------------------------
// quant4_int8_block_dot
// Dot product of 4-bit weight blocks with 8-bit activation blocks, float sum.
// ----------------------------------------------------------------------------
// Flow: a block pair is taken only in idle, once the previous pair has gone
//   twice through the three-stage multiplier and once through the adder.
// Result: emitted after the last beat's sum is added; while the sink
//   still holds the previous result, the emit waits until it is taken.
// Reset: synchronous, active low; clears the running sum to +0.0 and the FSM.
// ----------------------------------------------------------------------------
`default_nettype none

module quant4_int8_block_dot (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // weight_codes_lo, weight_codes_hi, act_group_0..3, weight_scale, act_scale
    input  wire logic [415:0]  i_s_axis_tdata,
    input  wire logic          i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // dot_sum
    output logic [31:0]        o_m_axis_tdata
);

    q4q8_pkg::t_state r_state;
    q4q8_pkg::t_state n_state;

    logic [q4q8_pkg::DATA_W-1:0] r_din;
    logic                        r_last;
    logic signed [14:0]          w_lane [q4q8_pkg::LANES];
    logic signed [16:0]          r_total;
    logic [31:0]                 r_scale;
    logic [31:0]                 r_term;
    logic [31:0]                 r_run;
    logic [31:0]                 r_odata;
    logic                        r_ovalid;

    logic                        w_accept;
    logic                        w_slot_free;
    logic                        w_mul_in;
    logic                        w_mul_term;
    logic                        w_add_in;
    logic                        w_emit;
    q4q8_pkg::t_fop              w_mul_a;
    q4q8_pkg::t_fop              w_mul_b;
    logic                        w_mul_valid;
    logic [31:0]                 w_mul_res;
    logic                        w_add_valid;
    logic [31:0]                 w_add_res;

    genvar g;
    generate
        for (g = 0; g < q4q8_pkg::LANES; g++) begin : g_lane
            q4q8_lane u_lane (
                .i_clk   (i_clk),
                .i_codes (r_din[32*g +: 32]),
                .i_acts  (r_din[128 + 64*g +: 64]),
                .o_sum   (w_lane[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_total <= 17'(w_lane[0]) + 17'(w_lane[1]) + 17'(w_lane[2]) + 17'(w_lane[3]);
    end

    assign w_mul_a = w_mul_term ? q4q8_pkg::unpack_float(r_scale)
                                : q4q8_pkg::unpack_half(r_din[399:384]);
    assign w_mul_b = w_mul_term ? q4q8_pkg::unpack_int(r_total)
                                : q4q8_pkg::unpack_half(r_din[415:400]);

    q4q8_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_in),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_valid (w_mul_valid),
        .o_res   (w_mul_res)
    );

    q4q8_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_add_in),
        .i_a     (r_run),
        .i_b     (r_term),
        .o_valid (w_add_valid),
        .o_res   (w_add_res)
    );

    assign w_slot_free = !r_ovalid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            q4q8_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) n_state = q4q8_pkg::S_LANE;
            end
            q4q8_pkg::S_LANE:    n_state = q4q8_pkg::S_SCALE_W;
            q4q8_pkg::S_SCALE_W: begin
                if (w_mul_valid) n_state = q4q8_pkg::S_TERM;
            end
            q4q8_pkg::S_TERM:    n_state = q4q8_pkg::S_TERM_W;
            q4q8_pkg::S_TERM_W: begin
                if (w_mul_valid) n_state = q4q8_pkg::S_ADD;
            end
            q4q8_pkg::S_ADD:     n_state = q4q8_pkg::S_ADD_W;
            q4q8_pkg::S_ADD_W: begin
                if (w_add_valid) n_state = r_last ? q4q8_pkg::S_EMIT : q4q8_pkg::S_IDLE;
            end
            q4q8_pkg::S_EMIT: begin
                if (w_slot_free) n_state = q4q8_pkg::S_IDLE;
            end
            default: n_state = q4q8_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == q4q8_pkg::S_IDLE);
        w_mul_in        = (r_state == q4q8_pkg::S_LANE) || (r_state == q4q8_pkg::S_TERM);
        w_mul_term      = (r_state == q4q8_pkg::S_TERM);
        w_add_in        = (r_state == q4q8_pkg::S_ADD);
        w_emit          = (r_state == q4q8_pkg::S_EMIT) && w_slot_free;
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_din  <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
        if ((r_state == q4q8_pkg::S_SCALE_W) && w_mul_valid) r_scale <= w_mul_res;
        if ((r_state == q4q8_pkg::S_TERM_W) && w_mul_valid)  r_term  <= w_mul_res;
        if (w_emit) r_odata <= r_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= q4q8_pkg::S_IDLE;
            r_run    <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_run <= 32'd0;
            end else if ((r_state == q4q8_pkg::S_ADD_W) && w_add_valid) begin
                r_run <= q4q8_pkg::canon_nan(w_add_res);
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_run == 32'd0))
        else $error("running sum not cleared after emit");

    a_mul_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_valid |-> (r_state == q4q8_pkg::S_SCALE_W || r_state == q4q8_pkg::S_TERM_W))
        else $error("multiplier result outside a wait state");

    a_add_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_valid |-> (r_state == q4q8_pkg::S_ADD_W))
        else $error("adder result outside its wait state");

    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[30:23] == 8'hFF) && (o_m_axis_tdata[22:0] != 23'd0))
        |-> (o_m_axis_tdata == q4q8_pkg::QNAN))
        else $error("non-canonical NaN on result beat");

endmodule

`default_nettype wire
